FILE: hdl/segmented_spring_damper_tension_assert.svh
// ----------------------------------------------------------------------------
// Spring tension assertion macros
// Concurrent check macros shared by the spring tension block; empty when
// synthesised.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_SPRING_DAMPER_TENSION_ASSERT_SVH
`define SEGMENTED_SPRING_DAMPER_TENSION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle while rst is high
`define SSTN_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spring tension check failed");
// Next-cycle implication, sampled on clk, idle while rst is high
`define SSTN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spring tension check failed");
`else
`define SSTN_ASSERT_IMPLIES(label, ante, cons)
`define SSTN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/sstn_pkg.sv
// ----------------------------------------------------------------------------
// Spring tension package
// Shared types and codes of the segmented spring tension block.
// ----------------------------------------------------------------------------
package sstn_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_NATURAL_LENGTH    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS         = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING           = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_TIME_STEP = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TENSION       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MODE        = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_SCALE    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRING_ENABLE     = 4'd7;

  localparam logic [1:0] MODE_COMPRESSION = 2'd1;
  localparam logic [1:0] MODE_EXTENSION   = 2'd2;

  localparam int CHUNK = 8;

  // Classification of a queued point
  typedef struct packed {
    logic seg;   // closes a segment with the previous point
    logic last;  // final point of the tick
  } kind_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  typedef enum logic [2:0] {
    OP_SQ, OP_LEN, OP_VEL, OP_ACC, OP_D2, OP_EN, OP_ELA, OP_VIS
  } mul_op_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_ROOT  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } back_state_t;

endpackage

FILE: hdl/segmented_spring_damper_tension.sv
// ----------------------------------------------------------------------------
// Segmented spring damper tension
// Kelvin-Voigt tension of a multi-segment spring from streamed attachment
// points.
// ----------------------------------------------------------------------------
// Points enter one per transaction and are classified by the front: a point
// that closes a segment or ends the tick goes into a two-entry queue, so the
// input side keeps taking points while the arithmetic back is busy, until the
// queue is full. The back runs everything through one byte-serial multiplier,
// a digit-serial square root (per segment) and a restoring divider (for the
// stretch ratio). One result transaction leaves per tick through an output
// register, and the back goes on with the next queued point while that result
// waits to be taken.
module segmented_spring_damper_tension #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [sstn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [WORD_WIDTH-2:0]              cfg_data,
  // point input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [WORD_WIDTH-1:0]              point_x,
  input  logic [WORD_WIDTH-1:0]              point_y,
  input  logic [WORD_WIDTH-1:0]              point_z,
  input  logic                               last_point,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [WORD_WIDTH-1:0]              total_tension,
  output logic [WORD_WIDTH-1:0]              elastic_tension,
  output logic [WORD_WIDTH-1:0]              viscous_tension,
  output logic [WORD_WIDTH-2:0]              current_length,
  output logic [WORD_WIDTH-1:0]              length_velocity,
  output logic [WORD_WIDTH-1:0]              length_acceleration,
  output logic [WORD_WIDTH-2:0]              stored_energy,
  output logic [WORD_WIDTH-1:0]              stretch,
  output logic [WORD_WIDTH-2:0]              stretch_ratio
);

`include "segmented_spring_damper_tension_assert.svh"

  localparam int W      = WORD_WIDTH;
  localparam int Q_DEPTH = 2;
  localparam int KIND_W = $bits(sstn_pkg::kind_t);
  localparam int Q_W    = 3 * W + KIND_W;

  // reset values: 1.0, 5000.0 and 1000.0 in the chosen fixed-point format
  localparam logic [W-2:0] RST_ONE   = (W-1)'(64'd1 << FRACTION_BITS);
  localparam logic [W-2:0] RST_STIFF = (W-1)'(64'd5000 << FRACTION_BITS);
  localparam logic [W-2:0] RST_ITS   = (W-1)'(64'd1000 << FRACTION_BITS);

  // Configuration registers
  logic [W-2:0] natural_length, stiffness, damping, inverse_time_step;
  logic [W-2:0] max_tension, distance_scale;
  logic [1:0]   force_mode;
  logic         spring_enable;
  logic         hist_clear;

  // Writing zero to the enable register also drops the velocity history
  assign hist_clear = cfg_wr_en && (cfg_index == sstn_pkg::REG_SPRING_ENABLE)
                      && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      natural_length    <= RST_ONE;
      stiffness         <= RST_STIFF;
      damping           <= RST_ONE;
      inverse_time_step <= RST_ITS;
      max_tension       <= '1;
      force_mode        <= 2'd0;
      distance_scale    <= RST_ONE;
      spring_enable     <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sstn_pkg::REG_NATURAL_LENGTH:    natural_length    <= cfg_data;
        sstn_pkg::REG_STIFFNESS:         stiffness         <= cfg_data;
        sstn_pkg::REG_DAMPING:           damping           <= cfg_data;
        sstn_pkg::REG_INVERSE_TIME_STEP: inverse_time_step <= cfg_data;
        sstn_pkg::REG_MAX_TENSION:       max_tension       <= cfg_data;
        sstn_pkg::REG_FORCE_MODE:        force_mode        <= cfg_data[1:0];
        sstn_pkg::REG_DISTANCE_SCALE:    distance_scale    <= cfg_data;
        sstn_pkg::REG_SPRING_ENABLE:     spring_enable     <= cfg_data[0];
        default: begin
          // ignore writes beyond the register list
        end
      endcase
    end
  end

  // Front: accept and classify points
  logic            push, q_full, q_empty;
  logic [W-1:0]    dist_x, dist_y, dist_z;
  sstn_pkg::kind_t kind;

  sstn_front #(.WORD_WIDTH(W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .q_full     (q_full),
    .push       (push),
    .dist_x     (dist_x),
    .dist_y     (dist_y),
    .dist_z     (dist_z),
    .kind       (kind)
  );

  // Queue between front and back
  logic [Q_W-1:0]         q_rd;
  sstn_pkg::back_status_t status;

  sstn_fifo #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({dist_x, dist_y, dist_z, kind}),
    .full    (q_full),
    .rd_en   (status.pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // Back: square root, length sum and tension sequence
  sstn_back #(.WORD_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .seg_dx              (q_rd[Q_W-1 -: W]),
    .seg_dy              (q_rd[Q_W-W-1 -: W]),
    .seg_dz              (q_rd[KIND_W+W-1 -: W]),
    .seg_kind            (sstn_pkg::kind_t'(q_rd[KIND_W-1:0])),
    .q_empty             (q_empty),
    .status              (status),
    .natural_length      (natural_length),
    .stiffness           (stiffness),
    .damping             (damping),
    .inverse_time_step   (inverse_time_step),
    .max_tension         (max_tension),
    .force_mode          (force_mode),
    .distance_scale      (distance_scale),
    .spring_enable       (spring_enable),
    .hist_clear          (hist_clear),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .total_tension       (total_tension),
    .elastic_tension     (elastic_tension),
    .viscous_tension     (viscous_tension),
    .current_length      (current_length),
    .length_velocity     (length_velocity),
    .length_acceleration (length_acceleration),
    .stored_energy       (stored_energy),
    .stretch             (stretch),
    .stretch_ratio       (stretch_ratio)
  );

  // The back only takes an entry that is there
  `SSTN_ASSERT_IMPLIES(a_pop_not_empty, status.pop, !q_empty)
  // One entry at a time: a pop is followed by work, never by another pop
  `SSTN_ASSERT_NEXT(a_single_pop, status.pop, !status.pop)
  // A new result only comes out of a running sequence
  `SSTN_ASSERT_IMPLIES(a_result_from_back, $rose(out_valid), $past(status.busy))

endmodule

FILE: hdl/sstn_fifo.sv
// ----------------------------------------------------------------------------
// Spring tension queue
// Short register queue between the point classifier and the arithmetic back.
// ----------------------------------------------------------------------------
module sstn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] level;

  assign full    = (level == CNT_W'(DEPTH));
  assign empty   = (level == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        level <= level + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        level <= level - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/sstn_front.sv
// ----------------------------------------------------------------------------
// Spring tension front
// Accept points, form per-axis distance magnitudes and classify each point.
// ----------------------------------------------------------------------------
module sstn_front #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_WIDTH-1:0] point_x,
  input  logic [WORD_WIDTH-1:0] point_y,
  input  logic [WORD_WIDTH-1:0] point_z,
  input  logic                  last_point,
  input  logic                  q_full,
  output logic                  push,
  output logic [WORD_WIDTH-1:0] dist_x,
  output logic [WORD_WIDTH-1:0] dist_y,
  output logic [WORD_WIDTH-1:0] dist_z,
  output sstn_pkg::kind_t       kind
);

  localparam int W = WORD_WIDTH;

  logic [W-1:0] prev_x, prev_y, prev_z;
  logic [1:0]   seen;
  logic         accept;

  function automatic logic [W-1:0] dist_mag(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    if (d[W]) begin
      d = ~d + (W+1)'(1);
    end
    return d[W-1:0];
  endfunction

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign kind.seg  = (seen != 2'd0);
  assign kind.last = last_point;
  assign dist_x    = dist_mag(point_x, prev_x);
  assign dist_y    = dist_mag(point_y, prev_y);
  assign dist_z    = dist_mag(point_z, prev_z);
  // drop points that neither close a segment nor end the tick
  assign push      = accept && (kind.seg || kind.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      prev_z <= '0;
      seen   <= 2'd0;
    end else if (accept) begin
      prev_x <= point_x;
      prev_y <= point_y;
      prev_z <= point_z;
      if (last_point) begin
        seen <= 2'd0;
      end else if (seen != 2'd2) begin
        seen <= seen + 2'd1;
      end
    end
  end

endmodule

FILE: hdl/sstn_mul.sv
// ----------------------------------------------------------------------------
// Spring tension multiplier
// Unsigned multiplier taking the second operand one byte per cycle.
// ----------------------------------------------------------------------------
module sstn_mul #(
  parameter int A_WIDTH = 66,
  parameter int B_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_WIDTH-1:0]   a,
  input  logic [B_WIDTH-1:0]   b,
  output logic                 done,
  output logic [A_WIDTH+((B_WIDTH+sstn_pkg::CHUNK-1)/sstn_pkg::CHUNK)*sstn_pkg::CHUNK-1:0] prod
);

  localparam int C     = sstn_pkg::CHUNK;
  localparam int NCH   = (B_WIDTH + C - 1) / C;
  localparam int BPW   = NCH * C;
  localparam int PW    = A_WIDTH + BPW;
  localparam int CNT_W = $clog2(NCH + 1);

  logic [A_WIDTH-1:0]   a_r;
  logic [BPW-1:0]       b_sh;
  logic [PW-1:0]        acc;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  logic [A_WIDTH+C-1:0] part;

  assign part = {{C{1'b0}}, a_r} * (A_WIDTH+C)'(b_sh[BPW-1 -: C]);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NCH);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // most significant byte first: shift the partial sum and add
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_sh <= BPW'(b);
      acc  <= '0;
    end else if (run) begin
      acc  <= (acc << C) + PW'(part);
      b_sh <= b_sh << C;
    end
  end

endmodule

FILE: hdl/sstn_back.sv
// ----------------------------------------------------------------------------
// Spring tension back
// Segment square root, length sum and end-of-tick tension sequence.
// ----------------------------------------------------------------------------
module sstn_back #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [WORD_WIDTH-1:0]      seg_dx,
  input  logic [WORD_WIDTH-1:0]      seg_dy,
  input  logic [WORD_WIDTH-1:0]      seg_dz,
  input  sstn_pkg::kind_t            seg_kind,
  input  logic                       q_empty,
  output sstn_pkg::back_status_t     status,
  input  logic [WORD_WIDTH-2:0]      natural_length,
  input  logic [WORD_WIDTH-2:0]      stiffness,
  input  logic [WORD_WIDTH-2:0]      damping,
  input  logic [WORD_WIDTH-2:0]      inverse_time_step,
  input  logic [WORD_WIDTH-2:0]      max_tension,
  input  logic [1:0]                 force_mode,
  input  logic [WORD_WIDTH-2:0]      distance_scale,
  input  logic                       spring_enable,
  input  logic                       hist_clear,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [WORD_WIDTH-1:0]      total_tension,
  output logic [WORD_WIDTH-1:0]      elastic_tension,
  output logic [WORD_WIDTH-1:0]      viscous_tension,
  output logic [WORD_WIDTH-2:0]      current_length,
  output logic [WORD_WIDTH-1:0]      length_velocity,
  output logic [WORD_WIDTH-1:0]      length_acceleration,
  output logic [WORD_WIDTH-2:0]      stored_energy,
  output logic [WORD_WIDTH-1:0]      stretch,
  output logic [WORD_WIDTH-2:0]      stretch_ratio
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int C   = sstn_pkg::CHUNK;
  localparam int AW  = 2 * W + 2;
  localparam int PW  = AW + ((W + C - 1) / C) * C;
  localparam int SW  = W + 8;
  localparam int DN  = W - 1 + F;
  localparam int CW  = $clog2(DN + 1);
  localparam int RW  = W + 4;
  localparam logic [W-2:0] POS_MAX = '1;

  sstn_pkg::back_state_t state;
  sstn_pkg::mul_op_t     op;

  logic [CW-1:0]   cnt;
  logic [1:0]      idx;
  logic [W-1:0]    d_r [3];
  sstn_pkg::kind_t kind_r;
  logic [AW-1:0]   sq_acc;
  logic [AW-1:0]   sv;
  logic [RW-1:0]   rem;
  logic [W:0]      root;
  logic [SW-1:0]   length_sum;
  logic [W-2:0]    len, prev_len, ratio, energy;
  logic [W-1:0]    str, vel, acc, ela, vis, prev_vel;
  logic [2*W-1:0]  d2;
  logic [DN-1:0]   div_sh;
  logic [W-2:0]    div_rem;
  logic            hv;

  logic            mul_start, mul_done;
  logic [AW-1:0]   mul_a;
  logic [W-1:0]    mul_b;
  logic [PW-1:0]   mul_prod;

  sstn_mul #(.A_WIDTH(AW), .B_WIDTH(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  function automatic logic [W-2:0] shr_sat(input logic [PW-1:0] p, input int unsigned s);
    logic [PW-1:0] m;
    m = p >> s;
    if (m > PW'(POS_MAX)) begin
      return POS_MAX;
    end
    return m[W-2:0];
  endfunction

  // drop fraction bits, saturate, then apply the sign
  function automatic logic [W-1:0] mulq(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] m;
    logic [PW-1:0] lim;
    logic [W-1:0]  mv;
    m   = p >> F;
    lim = PW'(POS_MAX) + (neg ? PW'(1) : PW'(0));
    if (m > lim) begin
      m = lim;
    end
    mv = m[W-1:0];
    return neg ? (~mv + W'(1)) : mv;
  endfunction

  function automatic logic [W-1:0] abs_w(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  logic [W-2:0] len_next;
  logic [W-1:0] str_next, ad, dl, vel_mag;
  logic [W:0]   dv, dv_mag;
  logic         ela_neg, vis_neg;

  assign len_next = shr_sat(mul_prod, F);
  assign str_next = {1'b0, len_next} - {1'b0, natural_length};
  assign ad       = abs_w(str);
  assign dl       = {1'b0, len} - {1'b0, prev_len};
  assign dv       = {vel[W-1], vel} - {prev_vel[W-1], prev_vel};
  assign dv_mag   = dv[W] ? (~dv + (W+1)'(1)) : dv;
  assign vel_mag  = abs_w(vel);
  assign ela_neg  = !str[W-1] && (str != '0);
  assign vis_neg  = !vel[W-1] && (vel != '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      sstn_pkg::OP_SQ: begin
        mul_a = AW'(d_r[idx]);
        mul_b = d_r[idx];
      end
      sstn_pkg::OP_LEN: begin
        mul_a = AW'(length_sum);
        mul_b = W'(distance_scale);
      end
      sstn_pkg::OP_VEL: begin
        mul_a = AW'(abs_w(dl));
        mul_b = W'(inverse_time_step);
      end
      sstn_pkg::OP_ACC: begin
        mul_a = AW'(dv_mag);
        mul_b = W'(inverse_time_step);
      end
      sstn_pkg::OP_D2: begin
        mul_a = AW'(ad);
        mul_b = ad;
      end
      sstn_pkg::OP_EN: begin
        mul_a = AW'(d2);
        mul_b = W'(stiffness);
      end
      sstn_pkg::OP_ELA: begin
        mul_a = AW'(ad);
        mul_b = W'(stiffness);
      end
      sstn_pkg::OP_VIS: begin
        mul_a = AW'(vel_mag);
        mul_b = W'(damping);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state == sstn_pkg::ST_ISSUE);

  // square root, one result bit per cycle
  logic [RW-1:0] r4, trial, rem_n;
  logic [W:0]    root_n;
  logic          r_ge;
  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_sat;

  assign r4      = {rem[RW-3:0], sv[AW-1 -: 2]};
  assign trial   = RW'({root, 2'b01});
  assign r_ge    = (r4 >= trial);
  assign rem_n   = r_ge ? (r4 - trial) : r4;
  assign root_n  = {root[W-1:0], r_ge};
  assign sum_ext = {1'b0, length_sum} + (SW+1)'(root_n);
  assign sum_sat = sum_ext[SW] ? '1 : sum_ext[SW-1:0];

  // restoring division, one quotient bit per cycle
  logic [W-1:0]  r2, r2_sub;
  logic          d_ge;
  logic [W-2:0]  drem_n;
  logic [DN-1:0] q_fin;

  assign r2     = {div_rem, div_sh[DN-1]};
  assign d_ge   = (r2 >= {1'b0, natural_length});
  assign r2_sub = r2 - {1'b0, natural_length};
  assign drem_n = d_ge ? r2_sub[W-2:0] : r2[W-2:0];
  assign q_fin  = {div_sh[DN-2:0], d_ge};

  // total tension: sum, clamp to the limit, apply the direction mode, zero when disabled
  logic signed [W:0] tot_sum, max_pos, max_neg, tot_lim;
  logic [W-1:0]      tot_c;

  always_comb begin
    tot_sum = $signed({ela[W-1], ela}) + $signed({vis[W-1], vis});
    max_pos = $signed({2'b00, max_tension});
    max_neg = -max_pos;
    tot_lim = tot_sum;
    priority if (tot_sum > max_pos) begin
      tot_lim = max_pos;
    end else if (tot_sum < max_neg) begin
      tot_lim = max_neg;
    end else begin
      tot_lim = tot_sum;
    end
    if ((force_mode == sstn_pkg::MODE_COMPRESSION) && (tot_lim < 0)) begin
      tot_lim = '0;
    end
    if ((force_mode == sstn_pkg::MODE_EXTENSION) && (tot_lim > 0)) begin
      tot_lim = '0;
    end
    tot_c = spring_enable ? tot_lim[W-1:0] : '0;
  end

  assign status.busy = (state != sstn_pkg::ST_IDLE);
  assign status.pop  = (state == sstn_pkg::ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sstn_pkg::ST_IDLE;
      op         <= sstn_pkg::OP_SQ;
      cnt        <= '0;
      idx        <= 2'd0;
      out_valid  <= 1'b0;
      hv         <= 1'b0;
      prev_vel   <= '0;
      prev_len   <= '0;
      length_sum <= '0;
    end else begin
      // the result state reloads the output register itself
      if (out_valid && !out_stall && (state != sstn_pkg::ST_OUT)) begin
        out_valid <= 1'b0;
      end
      if (hist_clear) begin
        prev_vel <= '0;
        hv       <= 1'b0;
      end
      unique case (state)
        sstn_pkg::ST_IDLE: begin
          if (!q_empty) begin
            d_r[0] <= seg_dx;
            d_r[1] <= seg_dy;
            d_r[2] <= seg_dz;
            kind_r <= seg_kind;
            idx    <= 2'd0;
            sq_acc <= '0;
            op     <= seg_kind.seg ? sstn_pkg::OP_SQ : sstn_pkg::OP_LEN;
            state  <= sstn_pkg::ST_ISSUE;
          end
        end
        sstn_pkg::ST_ISSUE: begin
          state <= sstn_pkg::ST_WAIT;
        end
        sstn_pkg::ST_WAIT: begin
          if (mul_done) begin
            unique case (op)
              sstn_pkg::OP_SQ: begin
                sq_acc <= sq_acc + mul_prod[AW-1:0];
                if (idx == 2'd2) begin
                  sv    <= sq_acc + mul_prod[AW-1:0];
                  rem   <= '0;
                  root  <= '0;
                  cnt   <= CW'(W + 1);
                  state <= sstn_pkg::ST_ROOT;
                end else begin
                  idx   <= idx + 2'd1;
                  state <= sstn_pkg::ST_ISSUE;
                end
              end
              sstn_pkg::OP_LEN: begin
                len     <= len_next;
                str     <= str_next;
                div_sh  <= {len_next, {F{1'b0}}};
                div_rem <= '0;
                cnt     <= CW'(DN);
                state   <= sstn_pkg::ST_DIV;
              end
              sstn_pkg::OP_VEL: begin
                vel   <= mulq(mul_prod, dl[W-1]);
                op    <= sstn_pkg::OP_ACC;
                state <= sstn_pkg::ST_ISSUE;
              end
              sstn_pkg::OP_ACC: begin
                acc   <= mulq(mul_prod, dv[W]);
                op    <= sstn_pkg::OP_D2;
                state <= sstn_pkg::ST_ISSUE;
              end
              sstn_pkg::OP_D2: begin
                d2    <= mul_prod[2*W-1:0];
                op    <= sstn_pkg::OP_EN;
                state <= sstn_pkg::ST_ISSUE;
              end
              sstn_pkg::OP_EN: begin
                energy <= shr_sat(mul_prod, 2 * F + 1);
                op     <= sstn_pkg::OP_ELA;
                state  <= sstn_pkg::ST_ISSUE;
              end
              sstn_pkg::OP_ELA: begin
                ela   <= mulq(mul_prod, ela_neg);
                op    <= sstn_pkg::OP_VIS;
                state <= sstn_pkg::ST_ISSUE;
              end
              sstn_pkg::OP_VIS: begin
                vis   <= mulq(mul_prod, vis_neg);
                state <= sstn_pkg::ST_OUT;
              end
              default: begin
                state <= sstn_pkg::ST_IDLE;
              end
            endcase
          end
        end
        sstn_pkg::ST_ROOT: begin
          rem  <= rem_n;
          root <= root_n;
          sv   <= sv << 2;
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            length_sum <= sum_sat;
            if (kind_r.last) begin
              op    <= sstn_pkg::OP_LEN;
              state <= sstn_pkg::ST_ISSUE;
            end else begin
              state <= sstn_pkg::ST_IDLE;
            end
          end
        end
        sstn_pkg::ST_DIV: begin
          div_rem <= drem_n;
          div_sh  <= q_fin;
          cnt     <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            ratio <= (q_fin > DN'(POS_MAX)) ? POS_MAX : q_fin[W-2:0];
            if (spring_enable) begin
              vel   <= '0;
              op    <= hv ? sstn_pkg::OP_VEL : sstn_pkg::OP_ACC;
              state <= sstn_pkg::ST_ISSUE;
            end else begin
              vel    <= '0;
              acc    <= '0;
              ela    <= '0;
              vis    <= '0;
              energy <= '0;
              state  <= sstn_pkg::ST_OUT;
            end
          end
        end
        sstn_pkg::ST_OUT: begin
          // hold until the output register is free or being taken
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            total_tension       <= tot_c;
            elastic_tension     <= ela;
            viscous_tension     <= vis;
            current_length      <= len;
            length_velocity     <= vel;
            length_acceleration <= acc;
            stored_energy       <= energy;
            stretch             <= str;
            stretch_ratio       <= ratio;
            prev_len            <= len;
            prev_vel            <= spring_enable ? vel : '0;
            hv                  <= spring_enable;
            length_sum          <= '0;
            state               <= sstn_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= sstn_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring tension block regression
// Streams attachment points into the segmented spring tension block, predicts
// each tick's tension result in the bench and compares every field.
// ----------------------------------------------------------------------------
module tb;

  localparam longint POS_MAX  = 64'h7FFF_FFFF;
  localparam longint SUM_MAX  = 64'hFF_FFFF_FFFF;
  localparam int     WATCHDOG = 60000;
  localparam int     SETTLE   = 600;

  // One tick's result, as the output ports carry it
  typedef struct {
    logic [31:0] tot, ela, vis;
    logic [30:0] len;
    logic [31:0] vel, acc;
    logic [30:0] energy;
    logic [31:0] str;
    logic [30:0] ratio;
  } tension_t;

  // Directed stimulus row; typed rows carry their result written out
  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
    bit          typed;
    tension_t    res;
  } point_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic        last_point = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] total_tension, elastic_tension, viscous_tension;
  logic [30:0] current_length, stored_energy, stretch_ratio;
  logic [31:0] length_velocity, length_acceleration, stretch;

  segmented_spring_damper_tension DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the spring's registers and history
  longint nat_len, spring_k, damp_b, inv_dt, tension_limit, scale;
  logic [1:0] mode;
  bit     enabled;
  longint last_pt [3];
  int     pts_seen;
  longint len_sum, prev_len, prev_vel;
  bit     history;

  tension_t tension_queue [$];
  int       fails = 0;
  int       cycle_count = 0;
  int       quiet_cycles = 0;
  bit       calm;

  // Hold a long stretch with no idling on either side in each period of the cycle count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end
  assign calm = (cycle_count % 16000) >= 12000;

  function automatic bit gap_now();
    return !calm && ($urandom_range(0, 99) < 6);
  endfunction

  function automatic void spring_reset();
    nat_len = 65536; spring_k = 327680000; damp_b = 65536; inv_dt = 65536000;
    tension_limit = POS_MAX; mode = 2'd0; scale = 65536; enabled = 1'b1;
    last_pt = '{0, 0, 0};
    pts_seen = 0; len_sum = 0; prev_len = 0; prev_vel = 0; history = 1'b0;
  endfunction

  // trunc(a*b / 2^16), saturated to a signed word
  function automatic longint fixed_mul(longint a, longint b);
    bit           neg;
    logic [127:0] p;
    longint       lim;
    neg = (a < 0) != (b < 0);
    p   = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    p   = p >> 16;
    lim = neg ? POS_MAX + 1 : POS_MAX;
    if (p > 128'(lim)) p = 128'(lim);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint floor_root(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return longint'(r);
  endfunction

  // Advance the spring by one point; returns 1 when the point ends a tick
  function automatic bit spring_step(logic [31:0] x, y, z, logic last,
                                     output tension_t res);
    longint       p [3];
    logic [127:0] sq, wide_v;
    longint       seg, len, str, ratio, q, r, vel, acc, ela, vis, tot, energy;
    p = '{longint'($signed(x)), longint'($signed(y)), longint'($signed(z))};
    if (pts_seen >= 1) begin
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        seg = p[i] - last_pt[i];
        if (seg < 0) seg = -seg;
        sq += 128'(seg) * 128'(seg);
      end
      seg = floor_root(sq);
      len_sum = (seg > SUM_MAX - len_sum) ? SUM_MAX : len_sum + seg;
    end
    last_pt = p;
    if (pts_seen < 2) pts_seen++;
    if (!last) return 1'b0;

    wide_v = (128'(len_sum) * 128'(scale)) >> 16;
    len = (wide_v > 128'(POS_MAX)) ? POS_MAX : longint'(wide_v);
    str = len - nat_len;
    len_sum = 0; pts_seen = 0;
    if (nat_len == 0) begin
      ratio = POS_MAX;
    end else begin
      q = len / nat_len;
      r = len % nat_len;
      if (q > (POS_MAX >> 16)) ratio = POS_MAX;
      else begin
        ratio = (q << 16) + (r << 16) / nat_len;
        if (ratio > POS_MAX) ratio = POS_MAX;
      end
    end
    vel = 0; acc = 0; ela = 0; vis = 0; tot = 0; energy = 0;
    if (enabled) begin
      if (history) vel = fixed_mul(len - prev_len, inv_dt);
      acc = fixed_mul(vel - prev_vel, inv_dt);
      wide_v = (128'(str < 0 ? -str : str) * 128'(str < 0 ? -str : str)
                * 128'(spring_k)) >> 33;
      energy = (wide_v > 128'(POS_MAX)) ? POS_MAX : longint'(wide_v);
      ela = fixed_mul(-str, spring_k);
      vis = fixed_mul(-vel, damp_b);
      tot = ela + vis;
      if (tot > tension_limit) tot = tension_limit;
      if (tot < -tension_limit) tot = -tension_limit;
      if (mode == sstn_pkg::MODE_COMPRESSION && tot < 0) tot = 0;
      if (mode == sstn_pkg::MODE_EXTENSION && tot > 0) tot = 0;
      prev_vel = vel;
      history  = 1'b1;
    end else begin
      prev_vel = 0;
      history  = 1'b0;
    end
    prev_len = len;
    res.tot = tot[31:0]; res.ela = ela[31:0]; res.vis = vis[31:0];
    res.len = len[30:0]; res.vel = vel[31:0]; res.acc = acc[31:0];
    res.energy = energy[30:0]; res.str = str[31:0]; res.ratio = ratio[30:0];
    return 1'b1;
  endfunction

  // Register write on the plain write port; mirror it into the bench copy
  task automatic write_reg(input logic [3:0] idx, input logic [30:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    case (idx)
      sstn_pkg::REG_NATURAL_LENGTH:    nat_len = value;
      sstn_pkg::REG_STIFFNESS:         spring_k = value;
      sstn_pkg::REG_DAMPING:           damp_b = value;
      sstn_pkg::REG_INVERSE_TIME_STEP: inv_dt = value;
      sstn_pkg::REG_MAX_TENSION:       tension_limit = value;
      sstn_pkg::REG_FORCE_MODE:        mode = value[1:0];
      sstn_pkg::REG_DISTANCE_SCALE:    scale = value;
      sstn_pkg::REG_SPRING_ENABLE: begin
        enabled = value[0];
        if (!value[0]) begin
          prev_vel = 0;
          history  = 1'b0;
        end
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Offer one point; hold it until the transaction completes
  task automatic send_point(input logic [31:0] x, y, z, input logic last,
                            input bit typed, input tension_t typed_res);
    tension_t res;
    @(negedge clk);
    while (gap_now()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    point_x    = x;
    point_y    = y;
    point_z    = z;
    last_point = last;
    do @(posedge clk); while (in_stall);
    if (spring_step(x, y, z, last, res))
      tension_queue.push_back(typed ? typed_res : res);
  endtask

  // Drain the pipe so registers can be rewritten safely
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tension_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] prev);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      1, 2: return $urandom;
      default: return prev + 32'($signed($urandom_range(0, 32'h7F_FFFF))
                                 - 32'sh40_0000);
    endcase
  endfunction

  function automatic logic [30:0] pick_value(int idx);
    case ($urandom_range(0, 5))
      0: return (idx == sstn_pkg::REG_NATURAL_LENGTH && $urandom_range(0, 1)) ? 31'd0 :
                (idx == sstn_pkg::REG_NATURAL_LENGTH ||
                 idx == sstn_pkg::REG_INVERSE_TIME_STEP) ? 31'd1 : 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: begin
        case (idx)
          sstn_pkg::REG_NATURAL_LENGTH:    return 31'(65536 * $urandom_range(1, 200));
          sstn_pkg::REG_STIFFNESS:         return 31'($urandom_range(0, 32'h0100_0000));
          sstn_pkg::REG_DAMPING:           return 31'($urandom_range(0, 32'h0010_0000));
          sstn_pkg::REG_INVERSE_TIME_STEP: return 31'(65536 * $urandom_range(1, 1000));
          sstn_pkg::REG_MAX_TENSION:       return 31'($urandom_range(0, 32'h4000_0000));
          default:                         return 31'($urandom_range(32768, 262144));
        endcase
      end
    endcase
  endfunction

  // Compare every arriving result against the oldest expectation
  always @(posedge clk) begin
    tension_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tension_queue.size() == 0) begin
        $error("result with no expectation waiting");
        fails = fails + 1;
      end else begin
        want = tension_queue.pop_front();
        if (total_tension !== want.tot) begin
          $error("total_tension: expected %h, actual %h", want.tot, total_tension);
          fails = fails + 1;
        end
        if (elastic_tension !== want.ela) begin
          $error("elastic_tension: expected %h, actual %h", want.ela, elastic_tension);
          fails = fails + 1;
        end
        if (viscous_tension !== want.vis) begin
          $error("viscous_tension: expected %h, actual %h", want.vis, viscous_tension);
          fails = fails + 1;
        end
        if (current_length !== want.len) begin
          $error("current_length: expected %h, actual %h", want.len, current_length);
          fails = fails + 1;
        end
        if (length_velocity !== want.vel) begin
          $error("length_velocity: expected %h, actual %h", want.vel, length_velocity);
          fails = fails + 1;
        end
        if (length_acceleration !== want.acc) begin
          $error("length_acceleration: expected %h, actual %h", want.acc,
                 length_acceleration);
          fails = fails + 1;
        end
        if (stored_energy !== want.energy) begin
          $error("stored_energy: expected %h, actual %h", want.energy, stored_energy);
          fails = fails + 1;
        end
        if (stretch !== want.str) begin
          $error("stretch: expected %h, actual %h", want.str, stretch);
          fails = fails + 1;
        end
        if (stretch_ratio !== want.ratio) begin
          $error("stretch_ratio: expected %h, actual %h", want.ratio, stretch_ratio);
          fails = fails + 1;
        end
      end
    end
  end

  // Stall the result side at random, away from the calm stretch
  always @(negedge clk) begin
    out_stall <= gap_now();
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("segmented_spring_damper_tension regression: fail");
      $finish;
    end
  end

  initial begin
    point_row_t rows [$];
    point_row_t row;
    tension_t   at_rest, none;
    logic [31:0] px, py, pz;
    int         npts;

    // A lone point at the default settings: zero length, no history
    at_rest = '{tot: 32'd327680000, ela: 32'd327680000, vis: '0, len: '0,
                vel: '0, acc: '0, energy: 31'd163840000, str: 32'hFFFF_0000,
                ratio: '0};
    none = at_rest;
    rows.push_back('{'0, '0, '0, 1'b1, 1'b1, at_rest});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, at_rest});
    rows.push_back('{'0, '0, '0, 1'b0, 1'b0, none});
    rows.push_back('{32'h3_0000, 32'h4_0000, '0, 1'b1, 1'b0, none});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, none});
    rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, none});
    rows.push_back('{32'hFFFF_FFFF, '0, 32'h5555_5555, 1'b0, 1'b0, none});
    rows.push_back('{32'hAAAA_AAAA, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, none});
    rows.push_back('{'0, 32'h1_0000, '0, 1'b0, 1'b0, none});
    rows.push_back('{'0, 32'h1_0000, '0, 1'b1, 1'b0, none});
    rows.push_back('{32'h2_0000, '0, '0, 1'b0, 1'b0, none});
    rows.push_back('{32'h1_8000, '0, '0, 1'b1, 1'b0, none});

    spring_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      send_point(row.x, row.y, row.z, row.last, row.typed, row.res);
    end
    settle();

    // Phases: write every register, then stream random ticks
    for (int phase = 0; phase < 11; phase++) begin
      for (int idx = 0; idx < 7; idx++) begin
        if (idx == sstn_pkg::REG_FORCE_MODE)
          write_reg(sstn_pkg::REG_FORCE_MODE, {29'($urandom), 2'(phase)});
        else if (phase == 0)
          write_reg(4'(idx), (idx == sstn_pkg::REG_NATURAL_LENGTH ||
                              idx == sstn_pkg::REG_INVERSE_TIME_STEP) ? 31'd1 : 31'd0);
        else if (phase == 1)
          write_reg(4'(idx), 31'h7FFF_FFFF);
        else
          write_reg(4'(idx), pick_value(idx));
      end
      write_reg(sstn_pkg::REG_SPRING_ENABLE, {30'($urandom), 1'(phase % 4 != 3)});
      write_reg(4'($urandom_range(8, 15)), 31'($urandom));

      for (int sent = 0; sent < 140; sent += npts) begin
        npts = ($urandom_range(0, 99) < 2) ? 140 : $urandom_range(1, 6);
        px = pick_coord($urandom); py = pick_coord($urandom); pz = pick_coord($urandom);
        for (int k = 0; k < npts; k++) begin
          if (npts == 140) begin
            // Long extreme zig-zag builds a large summed length
            px = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            py = px; pz = px;
          end else begin
            px = pick_coord(px); py = pick_coord(py); pz = pick_coord(pz);
          end
          send_point(px, py, pz, k == npts - 1 || $urandom_range(0, 49) == 0,
                     1'b0, none);
        end
      end
      settle();
    end

    if (fails == 0) begin
      $display("segmented_spring_damper_tension regression: pass");
    end else begin
      $display("segmented_spring_damper_tension regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sstn_pkg.sv
hdl/sstn_fifo.sv
hdl/sstn_front.sv
hdl/sstn_mul.sv
hdl/sstn_back.sv
hdl/segmented_spring_damper_tension.sv
bench/tb.sv
